### hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath interface types for the
// text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 30;
    localparam int CELLS   = COLUMNS * ROWS;

    // field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 12;
    localparam int CELL_W = 16;

    // blank cell and special characters
    localparam logic [7:0] BLANK_COLOUR = 8'hff;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0a;
    localparam logic [7:0] CH_RETURN    = 8'h0d;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_DELETE    = 8'h7f;

    // command codes
    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // datapath operation for the current cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_COPY,
        OP_FILL,
        OP_CLEAR,
        OP_FINISH
    } t_dp_op;

    // controller to datapath
    typedef struct packed {
        t_dp_op op;
        logic   out_now;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic scroll;
        logic copy_last;
        logic fill_last;
    } t_sts;

endpackage

### hw/rtl/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console writer: 80 x 30 cell buffer with cursor, scroll, clear
// and cell read-back.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one command per transfer:
//   put character, clear screen, read cell or none. Output channel (o_out_valid /
//   i_out_stall) returns one result per command: cursor after the command,
//   the cell read (zero for other commands) and a scroll flag.
//   Command handling:
//     put character without scroll: result registered in the cycle after the
//       transfer, one command per cycle while the output does not stall
//     read cell: read through the buffer read port, result loaded in S_FINISH
//     put character with scroll: the row copy runs one cell a cycle through
//       the single read and write port, then the bottom row is blanked one
//       cell a cycle
//     clear screen: one cell written a cycle
//   Reset clears the cursor to column 0, row 0 and empties the result
//   register; the buffer is not initialised, so software clears it first.
//   While a result waits under stall the block holds it and takes a new
//   command only once that result has been taken or is taken in that cycle.
// ----------------------------------------------------------------------------
module text_console_writer_core
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_char_code,
    input  logic [23:0]       i_rgb_color,
    input  logic [ADDR_W-1:0] i_cell_index,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [COL_W-1:0]  o_cursor_column,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic [7:0]        o_cell_color,
    output logic [7:0]        o_cell_char,
    output logic              o_scrolled
);

    t_ctl ctl;
    t_sts sts;

    // sequencer
    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_ctl      (ctl)
    );

    // buffer, cursor and result register
    tcw_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_command       (i_command),
        .i_char_code     (i_char_code),
        .i_rgb_color     (i_rgb_color),
        .i_cell_index    (i_cell_index),
        .i_out_stall     (i_out_stall),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row),
        .o_cell_color    (o_cell_color),
        .o_cell_char     (o_cell_char),
        .o_scrolled      (o_scrolled)
    );

endmodule

### hw/rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the text console writer: accepts commands and steps the
// datapath through scroll, fill and clear sweeps over the cell buffer.
// ----------------------------------------------------------------------------
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_command,
    input  t_sts       i_sts,
    output logic       o_in_stall,
    output t_ctl       o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COPY,
        S_DRAIN,
        S_FILL,
        S_CLEAR,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   ready;
    logic   accept;

    // input side handshake
    assign ready      = (r_state == S_IDLE) && i_sts.out_free;
    assign accept     = ready && i_in_valid;
    assign o_in_stall = !ready;

    // next state and datapath commands
    always_comb begin
        n_state       = r_state;
        o_ctl.op      = OP_NONE;
        o_ctl.out_now = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_ctl.op = OP_ACCEPT;
                    case (t_cmd'(i_command))
                        CMD_PUT: begin
                            if (i_sts.scroll) begin
                                n_state = S_COPY;
                            end else begin
                                o_ctl.out_now = 1'b1;
                            end
                        end
                        CMD_CLEAR: n_state = S_CLEAR;
                        CMD_READ:  n_state = S_FINISH;
                        default:   o_ctl.out_now = 1'b1;
                    endcase
                end
            end
            S_COPY: begin
                o_ctl.op = OP_COPY;
                if (i_sts.copy_last) begin
                    n_state = S_DRAIN;
                end
            end
            // last copied cell is written back here
            S_DRAIN: n_state = S_FILL;
            S_FILL: begin
                o_ctl.op = OP_FILL;
                if (i_sts.fill_last) begin
                    n_state = S_FINISH;
                end
            end
            S_CLEAR: begin
                o_ctl.op = OP_CLEAR;
                if (i_sts.fill_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_ctl.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell buffer, cursor, sweep counter and result register of the text
// console writer.
// ----------------------------------------------------------------------------
module tcw_datapath
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_char_code,
    input  logic [23:0]       i_rgb_color,
    input  logic [ADDR_W-1:0] i_cell_index,
    input  logic              i_out_stall,
    output t_sts              o_sts,
    output logic              o_out_valid,
    output logic [COL_W-1:0]  o_cursor_column,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic [7:0]        o_cell_color,
    output logic [7:0]        o_cell_char,
    output logic              o_scrolled
);

    logic [CELL_W-1:0] mem [CELLS];

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_dst;
    logic              r_wr_pend;
    logic [CELL_W-1:0] r_rd_data;
    logic              r_scr;
    logic              r_rd_sel;
    logic              r_out_valid;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [7:0]        r_out_colour;
    logic [7:0]        r_out_char;
    logic              r_out_scr;

    logic [7:0]        colour;
    logic [COL_W:0]    col_inc;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  put_col;
    logic [7:0]        put_char;
    logic              put_we;
    logic [ADDR_W-1:0] put_addr;
    logic              scroll;
    logic              is_put;
    logic              rd_in_range;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [CELL_W-1:0] wd;
    logic              rd_en;
    logic [ADDR_W-1:0] ra;
    logic              out_free;

    // 2-3-3 colour reduction
    assign colour = {i_rgb_color[23:22], i_rgb_color[15:13], i_rgb_color[7:5]};
    assign col_inc = {1'b0, r_col} + 1'b1;
    assign is_put  = (t_cmd'(i_command) == CMD_PUT);

    // character interpretation
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        put_col  = r_col;
        put_char = i_char_code;
        put_we   = 1'b0;
        if (i_char_code == CH_NEWLINE) begin
            n_col = '0;
            n_row = r_row + 1'b1;
        end else if (i_char_code == CH_RETURN) begin
            n_row = r_row + 1'b1;
        end else if (i_char_code == CH_BACKSPACE || i_char_code == CH_DELETE) begin
            if (r_col != '0) begin
                n_col    = r_col - 1'b1;
                put_col  = r_col - 1'b1;
                put_char = BLANK_CHAR;
                put_we   = 1'b1;
            end
        end else begin
            put_we = 1'b1;
            if (col_inc >= (COL_W+1)'(COLUMNS)) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
    end

    assign put_addr = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(put_col);
    assign scroll   = (n_row >= ROW_W'(ROWS - 1));

    // status to the controller
    assign out_free          = !r_out_valid || !i_out_stall;
    assign o_sts.out_free    = out_free;
    assign o_sts.scroll      = scroll;
    assign o_sts.copy_last   = (r_addr == ADDR_W'(CELLS - COLUMNS - 1));
    assign o_sts.fill_last   = (r_addr == ADDR_W'(CELLS - 1));

    // write port: pending copy first, then sweeps, then put character
    always_comb begin
        we = 1'b0;
        wa = r_addr;
        wd = {BLANK_COLOUR, BLANK_CHAR};
        if (r_wr_pend) begin
            we = 1'b1;
            wa = r_dst;
            wd = r_rd_data;
        end else if (i_ctl.op == OP_FILL || i_ctl.op == OP_CLEAR) begin
            we = 1'b1;
        end else if (i_ctl.op == OP_ACCEPT && is_put && put_we) begin
            we = 1'b1;
            wa = put_addr;
            wd = {colour, put_char};
        end
    end

    // read port: copy source during scroll, cell index on read command
    assign rd_in_range = (i_cell_index < ADDR_W'(CELLS));
    always_comb begin
        rd_en = 1'b0;
        ra    = r_addr + ADDR_W'(COLUMNS);
        if (i_ctl.op == OP_COPY) begin
            rd_en = 1'b1;
        end else if (i_ctl.op == OP_ACCEPT && t_cmd'(i_command) == CMD_READ
                     && rd_in_range) begin
            rd_en = 1'b1;
            ra    = i_cell_index;
        end
    end

    // cell buffer
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_data <= mem[ra];
        end
    end

    // cursor, sweep counter and copy bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= (i_ctl.op == OP_COPY);
            if (i_ctl.op == OP_ACCEPT && is_put) begin
                r_col <= n_col;
                r_row <= scroll ? ROW_W'(ROWS - 2) : n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dst <= r_addr;
        case (i_ctl.op)
            OP_ACCEPT: begin
                r_addr   <= '0;
                r_scr    <= is_put && scroll;
                r_rd_sel <= (t_cmd'(i_command) == CMD_READ) && rd_in_range;
            end
            OP_COPY, OP_FILL, OP_CLEAR: r_addr <= r_addr + 1'b1;
            default: r_addr <= r_addr;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_now || i_ctl.op == OP_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_now) begin
            r_out_col    <= is_put ? n_col : r_col;
            r_out_row    <= is_put ? n_row : r_row;
            r_out_colour <= '0;
            r_out_char   <= '0;
            r_out_scr    <= 1'b0;
        end else if (i_ctl.op == OP_FINISH) begin
            r_out_col    <= r_col;
            r_out_row    <= r_row;
            r_out_colour <= r_rd_sel ? r_rd_data[15:8] : 8'h00;
            r_out_char   <= r_rd_sel ? r_rd_data[7:0] : 8'h00;
            r_out_scr    <= r_scr;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cursor_column = r_out_col;
    assign o_cursor_row    = r_out_row;
    assign o_cell_color    = r_out_colour;
    assign o_cell_char     = r_out_char;
    assign o_scrolled      = r_out_scr;

endmodule
